// File: rtl/ndl_pkg.sv
// ndl_pkg: shared constants, tables and types for the ni1000 divider linearizer
// used by ndl_divider and ni1000_divider_linearizer; no dependencies
`default_nettype none

package ndl_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int WIRE_W   = 14;
    localparam int TEMP_W   = 16;
    localparam int STAT_W   = 2;

    // table size
    localparam int TABLE_POINTS  = 16;
    localparam int STORED_POINTS = 16;
    localparam int USED_POINTS   = (TABLE_POINTS > STORED_POINTS) ? STORED_POINTS :
                                   (TABLE_POINTS < 2) ? 2 : TABLE_POINTS;
    localparam int IDX_W = $clog2(STORED_POINTS);

    // datapath widths
    localparam int U_W    = 37;     // divider voltage, 1e-7 mV units
    localparam int A_W    = 63;     // numerator u * 64e6
    localparam int DIVN_W = 63;     // shared divider numerator
    localparam int DIVD_W = 44;     // shared divider divisor
    localparam int QUO_W  = 21;     // shared divider quotient
    localparam int CNT_W  = $clog2(QUO_W);
    localparam int RES_W  = 17;     // table resistance, 1/64 ohm
    localparam int DY_W   = 14;     // table segment width and offset
    localparam int DX_W   = 16;     // table temperature step

    // voltage mapping and divider constants
    localparam logic [U_W-1:0]  VOLT_OFFSET = 37'd6820720000;
    localparam logic [19:0]     VOLT_STEP   = 20'd984595;
    localparam logic [U_W-1:0]  VOLT_REF    = 37'd100000000000;
    localparam logic [19:0]     MILLION     = 20'd1000000;
    localparam logic [6:0]      HUNDRED     = 7'd100;

    // range limits in 1/64 ohm
    localparam logic [QUO_W-1:0] LOW_LIMIT  = 21'd50560;
    localparam logic [QUO_W-1:0] HIGH_LIMIT = 21'd124800;

    localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -16'sd5000;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 16'sd17400;

    // range status codes
    localparam logic [STAT_W-1:0] STAT_INTERP = 2'd0;
    localparam logic [STAT_W-1:0] STAT_LOW    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_HIGH   = 2'd2;

    // ni1000 table, resistance in 1/64 ohm, temperature in 0.01 C
    localparam logic [RES_W-1:0] RES_TAB [STORED_POINTS] = '{
        17'd50616, 17'd54474, 17'd58463, 17'd62592, 17'd66867, 17'd71295,
        17'd75885, 17'd80644, 17'd85578, 17'd90694, 17'd96001, 17'd101504,
        17'd107212, 17'd113132, 17'd119270, 17'd125635
    };

    localparam logic signed [TEMP_W-1:0] TEMP_TAB [STORED_POINTS] = '{
        -16'sd5000, -16'sd3500, -16'sd2000, -16'sd500, 16'sd1000, 16'sd2500,
        16'sd4000, 16'sd5500, 16'sd7000, 16'sd8500, 16'sd10000, 16'sd11500,
        16'sd13000, 16'sd14500, 16'sd16000, 16'sd17500
    };

    // shared divider result
    typedef struct packed {
        logic             done;
        logic             rem_nz;
        logic [QUO_W-1:0] quotient;
    } div_res_t;

endpackage

`default_nettype wire

// File: rtl/ndl_divider.sv
// ndl_divider: shared restoring divider, one quotient bit per cycle
// depends on ndl_pkg; numerator must be below divisor shifted by QUO_W
`default_nettype none

module ndl_divider (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [ndl_pkg::DIVN_W-1:0] num,
    input  wire logic [ndl_pkg::DIVD_W-1:0] den,
    output ndl_pkg::div_res_t              res
);
    import ndl_pkg::*;

    localparam int SH_W = DIVD_W + QUO_W - 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIVN_W-1:0] rem_reg;
    logic [SH_W-1:0]  dsh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             ge;

    // trial compare of remainder against shifted divisor
    assign ge = {{(SH_W-DIVN_W){1'b0}}, rem_reg} >= dsh_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dsh_reg <= {den, {(QUO_W-1){1'b0}}};
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg[DIVN_W-1:0];
            end
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign res.done     = done_reg;
    assign res.rem_nz   = (rem_reg != '0);
    assign res.quotient = quo_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without a pass");
    a_last_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg == '0 && !start) |=> done_reg)
        else $error("last step gave no done");

endmodule

`default_nettype wire

// File: rtl/ni1000_divider_linearizer.sv
// ni1000_divider_linearizer: converter sample to ni1000 temperature
// depends on ndl_pkg and ndl_divider
//
//  channel  ports                               direction
//  s_       s_valid s_ready s_sample            word in
//  m_       m_valid m_ready m_temperature       word out
//           m_range_status
//  cfg_     cfg_we cfg_wdata (wire_resistance)  register write
//
// one word at a time: no divider pass when the wire resistance exceeds the divider
// resistance, one pass when the divider resistance clamps, two when interpolated
// s_ready is high only between words; the next word may enter while a result waits
// a finished result waits in the sequencer if the output register is still full
// aresetn is synchronous, active low; wire_resistance resets to 0
`default_nettype none

module ni1000_divider_linearizer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [ndl_pkg::SAMPLE_W-1:0]       s_sample,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [ndl_pkg::TEMP_W-1:0]       m_temperature,
    output logic [ndl_pkg::STAT_W-1:0]              m_range_status,
    input  wire logic                               cfg_we,
    input  wire logic [ndl_pkg::WIRE_W-1:0]         cfg_wdata
);
    import ndl_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DEN    = 9'b000000010,
        ST_WIRE   = 9'b000000100,
        ST_DIFF   = 9'b000001000,
        ST_DIVR   = 9'b000010000,
        ST_SEARCH = 9'b000100000,
        ST_IMUL   = 9'b001000000,
        ST_DIVI   = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [WIRE_W-1:0]  wire_reg;
    logic [U_W-1:0]     u_reg;
    logic [U_W-1:0]     den_reg;
    logic [A_W-1:0]     a_reg;
    logic [A_W-1:0]     b_reg;
    logic [DIVD_W-1:0]  d_reg;
    logic [QUO_W-1:0]   r_reg;
    logic [DY_W-1:0]    q_reg;
    logic [DY_W-1:0]    dy_reg;
    logic [DX_W-1:0]    dx_reg;
    logic signed [TEMP_W-1:0] base_reg;
    logic signed [TEMP_W-1:0] res_temp_reg;
    logic [STAT_W-1:0]  res_stat_reg;
    logic               m_valid_reg;
    logic signed [TEMP_W-1:0] m_temp_reg;
    logic [STAT_W-1:0]  m_stat_reg;

    logic               accept;
    logic               out_free;
    logic [56:0]        a_prod;
    logic [50:0]        b_prod;
    logic               neg;
    logic [A_W-1:0]     diff;
    logic               lt_first;
    logic               gt_last;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        inum;
    logic               div_start;
    logic [DIVN_W-1:0]  div_num;
    logic [DIVD_W-1:0]  div_den;
    div_res_t           div_res;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // wide products and difference
    assign a_prod = 57'(u_reg) * 57'(MILLION);
    assign b_prod = 51'(wire_reg) * 51'(den_reg);
    assign neg    = a_reg < b_reg;
    assign diff   = a_reg - b_reg;

    // segment search over the table
    always_comb begin
        idx = IDX_W'(1);
        for (int i = 1; i < USED_POINTS - 1; i++) begin
            if (r_reg > QUO_W'(RES_TAB[i])) begin
                idx = idx + 1'b1;
            end
        end
    end
    assign lt_first = r_reg < QUO_W'(RES_TAB[0]);
    assign gt_last  = r_reg > QUO_W'(RES_TAB[USED_POINTS-1]);

    // rounded interpolation numerator
    assign inum = ({18'd0, q_reg} * {16'd0, dx_reg} << 1) + {18'd0, dy_reg};

    // shared divider operands
    always_comb begin
        div_start = 1'b0;
        div_num   = diff;
        div_den   = d_reg;
        if (state_reg == ST_DIFF) begin
            div_start = !neg;
        end else if (state_reg == ST_IMUL) begin
            div_start = 1'b1;
            div_num   = DIVN_W'(inum);
            div_den   = DIVD_W'({dy_reg, 1'b0});
        end
    end

    ndl_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .res     (div_res)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_DEN;
            ST_DEN:    state_next = ST_WIRE;
            ST_WIRE:   state_next = ST_DIFF;
            ST_DIFF:   state_next = neg ? ST_DONE : ST_DIVR;
            ST_DIVR: begin
                if (div_res.done) begin
                    if (div_res.quotient < LOW_LIMIT ||
                        div_res.quotient > HIGH_LIMIT ||
                        (div_res.quotient == HIGH_LIMIT && div_res.rem_nz)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: state_next = (lt_first || gt_last) ? ST_DONE : ST_IMUL;
            ST_IMUL:   state_next = ST_DIVI;
            ST_DIVI:   if (div_res.done) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wire_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                wire_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    u_reg <= VOLT_OFFSET + U_W'(36'(s_sample) * 36'(VOLT_STEP));
                end
            end
            ST_DEN: begin
                den_reg <= VOLT_REF - u_reg;
                a_reg   <= {a_prod[A_W-7:0], 6'd0};
            end
            ST_WIRE: begin
                b_reg <= A_W'({b_prod, 6'd0});
                d_reg <= DIVD_W'(44'(den_reg) * 44'(HUNDRED));
            end
            ST_DIFF: begin
                if (neg) begin
                    res_temp_reg <= TEMP_LOW;
                    res_stat_reg <= STAT_LOW;
                end
            end
            ST_DIVR: begin
                if (div_res.done) begin
                    r_reg <= div_res.quotient;
                    if (div_res.quotient < LOW_LIMIT) begin
                        res_temp_reg <= TEMP_LOW;
                        res_stat_reg <= STAT_LOW;
                    end else begin
                        res_temp_reg <= TEMP_HIGH;
                        res_stat_reg <= STAT_HIGH;
                    end
                end
            end
            ST_SEARCH: begin
                res_stat_reg <= STAT_INTERP;
                res_temp_reg <= lt_first ? TEMP_TAB[0] : TEMP_TAB[USED_POINTS-1];
                q_reg    <= DY_W'(r_reg - QUO_W'(RES_TAB[idx - 1'b1]));
                dy_reg   <= DY_W'(RES_TAB[idx] - RES_TAB[idx - 1'b1]);
                dx_reg   <= DX_W'(TEMP_TAB[idx] - TEMP_TAB[idx - 1'b1]);
                base_reg <= TEMP_TAB[idx - 1'b1];
            end
            ST_IMUL: begin
                res_stat_reg <= STAT_INTERP;
            end
            ST_DIVI: begin
                if (div_res.done) begin
                    res_temp_reg <= base_reg + TEMP_W'(div_res.quotient);
                end
            end
            ST_DONE: begin
                res_stat_reg <= res_stat_reg;
            end
            default: begin
                res_stat_reg <= res_stat_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_temp_reg <= res_temp_reg;
            m_stat_reg <= res_stat_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_temperature  = m_temp_reg;
    assign m_range_status = m_stat_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_DEN)) else $error("word accepted but not started");
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIVR || state_reg == ST_DIVI))
        else $error("divider finished outside a divide state");
    a_low_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_range_status == STAT_LOW) |-> (m_temperature == TEMP_LOW))
        else $error("low clamp with wrong temperature");

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking testbench for ni1000_divider_linearizer
// depends on ndl_pkg and the rtl of the block; drives samples and wire resistance
// and checks every temperature word against its own fixed-point model
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ndl_pkg::*;

    typedef struct {
        logic signed [TEMP_W-1:0] temperature;
        logic [STAT_W-1:0]        status;
    } reading_t;

    // expected temperatures and their checking
    class temp_scoreboard;
        reading_t           expected_q[$];
        logic [WIRE_W-1:0]  wire_res;
        int                 errors;

        function new();
            wire_res = '0;
            errors   = 0;
        endfunction

        // linear interpolation in the ni1000 table, r in 1/64 ohm
        function logic signed [TEMP_W-1:0] table_lookup(longint r);
            int  seg;
            longint q, dx, dy, num;
            seg = 1;
            if (r < RES_TAB[0]) return TEMP_TAB[0];
            if (r > RES_TAB[USED_POINTS-1]) return TEMP_TAB[USED_POINTS-1];
            while (seg < USED_POINTS - 1 && r > RES_TAB[seg]) seg++;
            q   = r - RES_TAB[seg-1];
            dx  = TEMP_TAB[seg] - TEMP_TAB[seg-1];
            dy  = RES_TAB[seg] - RES_TAB[seg-1];
            num = q * dx;
            if (num >= 0) return TEMP_TAB[seg-1] + (2 * num + dy) / (2 * dy);
            return TEMP_TAB[seg-1] - (2 * -num - dy + 2 * dy - 1) / (2 * dy);
        endfunction

        // sample to expected reading under the current wire resistance
        function reading_t convert(logic [SAMPLE_W-1:0] sample);
            longint unsigned volt, den, num_a, num_b, dvs, diff;
            longint          r;
            reading_t        res;
            volt  = 64'd6820720000 + longint'(sample) * 64'd984595;
            den   = 64'd100000000000 - volt;
            num_a = volt * 64'd64000000;
            num_b = longint'(wire_res) * 64 * den;
            dvs   = 100 * den;
            if (num_a < num_b) begin
                res.temperature = TEMP_LOW;
                res.status      = STAT_LOW;
            end else begin
                diff = num_a - num_b;
                r    = longint'(diff / dvs);
                if (r < 790 * 64) begin
                    res.temperature = TEMP_LOW;
                    res.status      = STAT_LOW;
                end else if (r > 1950 * 64 || (r == 1950 * 64 && (diff % dvs) != 0)) begin
                    res.temperature = TEMP_HIGH;
                    res.status      = STAT_HIGH;
                end else begin
                    res.temperature = table_lookup(r);
                    res.status      = STAT_INTERP;
                end
            end
            return res;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] sample);
            expected_q.push_back(convert(sample));
        endfunction

        function void check_reading(logic signed [TEMP_W-1:0] temp, logic [STAT_W-1:0] stat);
            reading_t exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word temperature=%0d status=%0d", $time, temp, stat);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (temp !== exp_r.temperature) begin
                $display("%0t: temperature expected %0d actual %0d", $time,
                         exp_r.temperature, temp);
                errors++;
            end
            if (stat !== exp_r.status) begin
                $display("%0t: range_status expected %0d actual %0d", $time,
                         exp_r.status, stat);
                errors++;
            end
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [SAMPLE_W-1:0]       s_sample;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [TEMP_W-1:0]  m_temperature;
    logic [STAT_W-1:0]         m_range_status;
    logic                      cfg_we;
    logic [WIRE_W-1:0]         cfg_wdata;

    temp_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;

    ni1000_divider_linearizer u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_temperature  (m_temperature),
        .m_range_status (m_range_status),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #30ms;
        $display("status: fail");
        $finish;
    end

    // result side: stalls and the long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result check
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_reading(m_temperature, m_range_status);
    end

    // offer one word, wait for acceptance
    task automatic send_word(logic [SAMPLE_W-1:0] sample);
        do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        s_valid  <= 1'b1;
        s_sample <= sample;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(sample);
        @(negedge aclk);
        s_valid  <= 1'b0;
        s_sample <= SAMPLE_W'($urandom);
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() != 0) @(negedge aclk);
    endtask

    // register write while the block is idle
    task automatic write_wire(logic [WIRE_W-1:0] value);
        wait_drained();
        repeat (60) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.wire_res = value;
    endtask

    // mostly samples within the table span, some anywhere
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(99);
        if (sel < 65) return SAMPLE_W'($urandom_range(10000, 400));
        if (sel < 80) return SAMPLE_W'($urandom_range(700, 400));
        return SAMPLE_W'($urandom);
    endfunction

    initial begin
        logic [WIRE_W-1:0] wire_vals [8];
        logic [SAMPLE_W-1:0] directed [$];
        sb = new();
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_sample        = '0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        wire_vals = '{14'd0, 14'd16383, 14'd10000, 14'd0, 14'd5000, 14'd1, 14'd16383, 14'd0};
        directed  = '{16'd0, 16'd65535, 16'd1, 16'd400, 16'd505, 16'd506, 16'd507, 16'd508,
                      16'd509, 16'd510, 16'd600, 16'd1000, 16'd3000, 16'd5000, 16'd8000,
                      16'd9600, 16'd9640, 16'd9650, 16'd9660, 16'd9700, 16'd32768,
                      16'd21845, 16'd43690};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            write_wire((ph == 3 || ph == 7) ? WIRE_W'($urandom) : wire_vals[ph]);
            // directed sweep across the clamps and the table under each of the first three settings
            if (ph < 3)
                foreach (directed[k]) send_word(directed[k]);
            for (int n = 0; n < 120; n++) begin
                // long receiver hold-off while words keep coming
                if (ph == 2 && n == 10) hold_off_cycles = 400;
                // sender pause until the block has drained
                if (ph == 5 && n == 60) wait_drained();
                send_word(pick_sample());
            end
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: files.f
rtl/ndl_pkg.sv
rtl/ndl_divider.sv
rtl/ni1000_divider_linearizer.sv
tb/tb.sv
